### rtl/core/cht_pkg.sv
// ============================================================================
// cht_pkg: shared constants for the coalesced hash table
// Status codes, request kinds and default table geometry.
// ============================================================================
package cht_pkg;
   localparam int unsigned TableSlots = 1024;
   localparam int unsigned KeyWidth   = 31;
   localparam int unsigned DataWidth  = 32;
   localparam int unsigned SlotOutW   = 10;

   localparam logic [1:0] KindFind   = 2'd0;
   localparam logic [1:0] KindInsert = 2'd1;
   localparam logic [1:0] KindRemove = 2'd2;
   localparam logic [1:0] KindUpdate = 2'd3;

   localparam logic [1:0] StatusOk       = 2'd0;
   localparam logic [1:0] StatusNotFound = 2'd1;
   localparam logic [1:0] StatusDup      = 2'd2;
   localparam logic [1:0] StatusFull     = 2'd3;
endpackage

### rtl/core/cht_ram.sv
// ============================================================================
// cht_ram: generic single-port synchronous RAM
// One write or one read per cycle; read data is registered.
// ============================================================================
module cht_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule

### rtl/core/coalesced_hash_table.sv
// Coalesced hash table. One operation at a time; each memory access takes
// a read phase and an evaluate phase: a chain walk visits slot by slot,
// an insert adds probe steps, a remove sweeps every slot.
// After reset a clearing pass marks every slot free with a null link;
// no request is taken during it.
// ============================================================================
// coalesced_hash_table: find, insert, remove and update over chained slots
// Slot state is one RAM word {used, link, key} plus a data RAM.
// ============================================================================
module coalesced_hash_table #(
   parameter int unsigned TABLE_SLOTS = cht_pkg::TableSlots
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: kind[1:0], key[32:2], payload[64:33], zero fill
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: status[1:0], slot[11:2], found_data[43:12], zero fill
   output logic [47:0] rsp_tdata
);
   localparam int unsigned AW = $clog2(TABLE_SLOTS);
   localparam int unsigned LW = AW + 1;
   localparam int unsigned CW = AW + 1;
   localparam int unsigned KW = cht_pkg::KeyWidth;
   localparam int unsigned DW = cht_pkg::DataWidth;
   localparam int unsigned MW = 1 + LW + KW;
   localparam int unsigned SlotOutW = cht_pkg::SlotOutW;
   localparam logic [CW-1:0] Slots = CW'(TABLE_SLOTS);

   localparam logic [3:0] StClear = 4'd0;
   localparam logic [3:0] StIdle  = 4'd1;
   localparam logic [3:0] StLook  = 4'd2;
   localparam logic [3:0] StEnd   = 4'd3;
   localparam logic [3:0] StProbe = 4'd4;
   localparam logic [3:0] StLink  = 4'd5;
   localparam logic [3:0] StSweep = 4'd6;
   localparam logic [3:0] StFree  = 4'd7;
   localparam logic [3:0] StData  = 4'd8;
   localparam logic [3:0] StResp  = 4'd9;
   localparam logic [3:0] StWait  = 4'd10;

   logic [3:0]    state_ff, state_in;
   logic          phase_ff, phase_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [LW-1:0] next_ff, next_in;
   logic [1:0]    kind_ff, kind_in;
   logic [KW-1:0] key_ff, key_in;
   logic [DW-1:0] pay_ff, pay_in;
   logic [1:0]    status_ff, status_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic          fdata_ff, fdata_in;
   logic          rvalid_ff, rvalid_in;

   logic          m_we, d_we;
   logic [AW-1:0] m_addr, d_addr;
   logic [MW-1:0] m_wdata, m_rdata;
   logic [DW-1:0] d_rdata;

   cht_ram #(.WIDTH(MW), .DEPTH(TABLE_SLOTS)) u_meta (
      .clock(clock), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata));
   cht_ram #(.WIDTH(DW), .DEPTH(TABLE_SLOTS)) u_data (
      .clock(clock), .we(d_we), .addr(d_addr), .wdata(pay_ff), .rdata(d_rdata));

   // Fields of the slot word just read.
   logic          r_used;
   logic [LW-1:0] r_link;
   logic [KW-1:0] r_key;
   logic          r_link_ok;
   logic [AW-1:0] home;
   assign r_used    = m_rdata[MW-1];
   assign r_link    = m_rdata[KW +: LW];
   assign r_key     = m_rdata[KW-1:0];
   assign r_link_ok = r_link < LW'(TABLE_SLOTS);
   assign home      = AW'(req_tdata[32:2] % TABLE_SLOTS);

   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {4'd0, (fdata_ff ? d_rdata : {DW{1'b0}}),
                        SlotOutW'(slot_ff), status_ff};

   // Sequencer: in the walking states, phase 0 issues a read, phase 1 evaluates the read data.
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      count_in  = count_ff;
      addr_in   = addr_ff;
      pos_in    = pos_ff;
      tail_in   = tail_ff;
      next_in   = next_ff;
      kind_in   = kind_ff;
      key_in    = key_ff;
      pay_in    = pay_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      fdata_in  = fdata_ff;
      rvalid_in = rvalid_ff;
      m_we      = 1'b0;
      m_addr    = addr_ff;
      m_wdata   = m_rdata;
      d_we      = 1'b0;
      d_addr    = pos_ff;
      unique case (state_ff)
         StClear: begin
            m_we    = 1'b1;
            m_wdata = {1'b0, {LW{1'b1}}, {KW{1'b0}}};
            addr_in = addr_ff + 1'b1;
            if (addr_ff == AW'(TABLE_SLOTS - 1)) begin
               state_in = StIdle;
            end
         end
         StIdle: begin
            if (req_tvalid) begin
               kind_in   = req_tdata[1:0];
               key_in    = req_tdata[32:2];
               pay_in    = req_tdata[64:33];
               addr_in   = home;
               count_in  = '0;
               phase_in  = 1'b0;
               status_in = cht_pkg::StatusNotFound;
               slot_in   = '0;
               fdata_in  = 1'b0;
               state_in  = StLook;
            end
         end
         StLook: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (r_used && r_key == key_ff) begin
                  pos_in  = addr_ff;
                  next_in = r_link;
                  unique case (kind_ff)
                     cht_pkg::KindFind: begin
                        status_in = cht_pkg::StatusOk;
                        slot_in   = addr_ff;
                        fdata_in  = 1'b1;
                        state_in  = StData;
                     end
                     cht_pkg::KindInsert: begin
                        status_in = cht_pkg::StatusDup;
                        slot_in   = addr_ff;
                        state_in  = StResp;
                     end
                     cht_pkg::KindRemove: begin
                        addr_in  = '0;
                        count_in = '0;
                        state_in = StSweep;
                     end
                     default: begin
                        d_we      = 1'b1;
                        d_addr    = addr_ff;
                        status_in = cht_pkg::StatusOk;
                        slot_in   = addr_ff;
                        state_in  = StResp;
                     end
                  endcase
               end else if (!r_link_ok || count_ff == Slots - 1'b1) begin
                  if (kind_ff == cht_pkg::KindInsert) begin
                     addr_in  = AW'(key_ff % TABLE_SLOTS);
                     count_in = '0;
                     state_in = StEnd;
                  end else begin
                     state_in = StResp;
                  end
               end else begin
                  addr_in  = AW'(r_link);
                  count_in = count_ff + 1'b1;
               end
            end
         end
         StEnd: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (!r_used) begin
                  m_we      = 1'b1;
                  m_wdata   = {1'b1, r_link, key_ff};
                  d_we      = 1'b1;
                  d_addr    = addr_ff;
                  status_in = cht_pkg::StatusOk;
                  slot_in   = addr_ff;
                  state_in  = StResp;
               end else if (!r_link_ok) begin
                  tail_in  = addr_ff;
                  next_in  = r_link;
                  count_in = '0;
                  state_in = StProbe;
               end else if (count_ff == Slots - 1'b1) begin
                  status_in = cht_pkg::StatusFull;
                  state_in  = StResp;
               end else begin
                  addr_in  = AW'(r_link);
                  count_in = count_ff + 1'b1;
               end
            end
         end
         StProbe: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (!r_used) begin
                  m_we     = 1'b1;
                  m_wdata  = {1'b1, r_link, key_ff};
                  d_we     = 1'b1;
                  d_addr   = addr_ff;
                  slot_in  = addr_ff;
                  pos_in   = addr_ff;
                  addr_in  = tail_ff;
                  state_in = StLink;
               end else if (count_ff == Slots - 1'b1) begin
                  status_in = cht_pkg::StatusFull;
                  state_in  = StResp;
               end else begin
                  addr_in  = (addr_ff == AW'(TABLE_SLOTS - 1)) ? '0 : addr_ff + 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         StLink: begin
            // Tail word read, then rewritten with the new link.
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in  = 1'b0;
               m_we      = 1'b1;
               m_wdata   = {r_used, LW'(pos_ff), r_key};
               status_in = cht_pkg::StatusOk;
               state_in  = StResp;
            end
         end
         StSweep: begin
            // Relink every predecessor of the removed slot.
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (r_link == LW'(pos_ff)) begin
                  m_we    = 1'b1;
                  m_wdata = {r_used, next_ff, r_key};
               end
               if (count_ff == Slots - 1'b1) begin
                  addr_in  = pos_ff;
                  state_in = StFree;
               end else begin
                  addr_in  = addr_ff + 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         StFree: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in  = 1'b0;
               m_we      = 1'b1;
               m_wdata   = {1'b0, r_link, r_key};
               status_in = cht_pkg::StatusOk;
               slot_in   = pos_ff;
               state_in  = StResp;
            end
         end
         StData: begin
            // Data RAM read of the hit slot lands next cycle.
            state_in = StResp;
         end
         StResp: begin
            rvalid_in = 1'b1;
            state_in  = StWait;
         end
         StWait: begin
            d_addr = pos_ff;
            if (rsp_tready) begin
               rvalid_in = 1'b0;
               state_in  = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= StClear;
         addr_ff   <= '0;
         phase_ff  <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         addr_ff   <= addr_in;
         phase_ff  <= phase_in;
         rvalid_ff <= rvalid_in;
      end
      count_ff  <= count_in;
      pos_ff    <= pos_in;
      tail_ff   <= tail_in;
      next_ff   <= next_in;
      kind_ff   <= kind_in;
      key_ff    <= key_in;
      pay_ff    <= pay_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      fdata_ff  <= fdata_in;
   end
endmodule
